// ===== design/legendre_position_embedding_core_defines.svh =====
// Assertion macros shared by the Legendre embedding RTL
`ifndef LEGENDRE_POSITION_EMBEDDING_CORE_DEFINES_SVH
`define LEGENDRE_POSITION_EMBEDDING_CORE_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define LPE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LPE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/legpe_pkg.sv =====
// Package: constants, types and codes of the Legendre position embedding core
`timescale 1ns / 1ps
package legpe_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int POS_BITS   = 16;
	localparam int MAX_ORDERS = 64;

	localparam int LEN_W   = POS_BITS + 1;
	localparam int CNT_W   = $clog2(MAX_ORDERS) + 1;
	localparam int ORDER_W = $clog2(MAX_ORDERS);
	localparam int VALUE_W = FRAC_BITS + 2;
	localparam int IDX_W   = 2;
	localparam int D_W     = POS_BITS;

	// register indexes
	localparam logic [IDX_W-1:0] REG_MAX_LENGTH  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_ORDER_COUNT = IDX_W'(1);

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(2048);
	localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
	localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(1) << POS_BITS;
	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(MAX_ORDERS);
	localparam logic [CNT_W-1:0] CNT_MIN   = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_ORDERS);

	// shared divider
	localparam int DIV_NUM_W = D_W + FRAC_BITS + 1;
	localparam int DVS_W     = D_W;
	localparam int X_STEPS   = FRAC_BITS + 1;
	localparam int QUOT_W    = FRAC_BITS + 8;
	localparam int ORD_STEPS = QUOT_W;
	localparam int STEP_W    = $clog2(DIV_NUM_W + 1);
	localparam int NUM_W     = VALUE_W + 8;

	localparam logic [QUOT_W-1:0] ONE_Q = QUOT_W'(1) << FRAC_BITS;

	typedef enum logic [0:0] {
		DIV_X,
		DIV_ORD
	} div_mode_t;

	typedef struct packed {
		logic                 go;
		div_mode_t            mode;
		logic [DIV_NUM_W-1:0] num;
		logic [DVS_W-1:0]     dvs;
	} div_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_XDIV,
		ST_EMIT,
		ST_MUL,
		ST_RND,
		ST_COMB,
		ST_OGO,
		ST_ODIV
	} state_t;

endpackage

// ===== design/legendre_position_embedding_core.sv =====
// Top level: Legendre position embedding, sequencer and datapath around a shared divider
`timescale 1ns / 1ps
`include "legendre_position_embedding_core_defines.svh"
// Usage
//   Input: drive position and pulse start; the item is taken at an edge with
//   start high and busy low. busy stays high until the item's run is out.
//   Results: one per order, order 0 .. order_count-1, each on order/value/last
//   for exactly one cycle with strobe high; last marks the final order.
//   The receiver cannot hold results off and need not.
//   Config: wr_en/wr_index/wr_data write max_length (index 0) and
//   order_count (index 1) while busy is low; other indexes are ignored.
//   Timing: order 0 appears once the x scaling division is done, order 1 in
//   the next cycle, and each higher order after the states MUL, RND, COMB,
//   OGO and ODIV, where ODIV waits on the bit-serial divider shared by the
//   x scaling and the recursion; busy drops the cycle after the last strobe.
//   Reset: max_length 2048, order_count 64, block idle, no strobe.
module legendre_position_embedding_core
	import legpe_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [POS_BITS-1:0]       position,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_index,
	input  logic [LEN_W-1:0]          wr_data,
	output logic                      strobe,
	output logic [ORDER_W-1:0]        order,
	output logic signed [VALUE_W-1:0] value,
	output logic                      last
);

	state_t state_q, state_d;

	logic [LEN_W-1:0]   max_length_q;
	logic [CNT_W-1:0]   order_count_q;
	logic [ORDER_W-1:0] n_q;

	logic [POS_BITS-1:0]        pos_q;
	logic [D_W-1:0]             d_q;
	logic [ORDER_W-1:0]         last_order_q;
	logic                       neg_q;
	logic signed [VALUE_W-1:0]  x_q;
	logic signed [VALUE_W-1:0]  val_q;
	logic signed [VALUE_W-1:0]  cur_q;
	logic signed [2*VALUE_W-1:0] prod_q;
	logic signed [VALUE_W-1:0]  q_q;
	logic [QUOT_W-1:0]          nmag_q;

	div_cmd_t          div_cmd;
	logic              div_done;
	logic [QUOT_W-1:0] div_quot;

	logic [LEN_W-1:0]   len_c;
	logic [CNT_W-1:0]   cnt_c;
	logic [D_W-1:0]     d_c;
	logic [ORDER_W-1:0] last_c;
	logic               accept;
	logic               is_last;

	logic [POS_BITS-1:0]  pos_c;
	logic [D_W:0]         two_pos;
	logic                 xneg;
	logic [D_W:0]         xmag;
	logic [DIV_NUM_W-1:0] xnum;

	logic [2*VALUE_W-1:0] pmag;
	logic [2*VALUE_W-1:0] psum;
	logic [VALUE_W-1:0]   qmag;
	logic signed [VALUE_W-1:0] q_c;

	logic signed [NUM_W-1:0] num_c;
	logic [NUM_W-1:0]        nmag_c;
	logic [ORDER_W:0]        coef_a;
	logic [ORDER_W-1:0]      den;

	logic [QUOT_W-1:0]         sat_mag;
	logic signed [VALUE_W-1:0] sat_val;
	logic signed [VALUE_W-1:0] res_c;

	legpe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.done   (div_done),
		.quot   (div_quot)
	);

	// register clamps
	always_comb begin
		if (max_length_q < LEN_MIN) begin
			len_c = LEN_MIN;
		end else if (max_length_q > LEN_MAX) begin
			len_c = LEN_MAX;
		end else begin
			len_c = max_length_q;
		end
		if (order_count_q < CNT_MIN) begin
			cnt_c = CNT_MIN;
		end else if (order_count_q > CNT_MAX) begin
			cnt_c = CNT_MAX;
		end else begin
			cnt_c = order_count_q;
		end
		d_c    = D_W'(len_c - LEN_W'(1));
		last_c = ORDER_W'(cnt_c - CNT_W'(1));
	end

	assign accept  = start && (state_q == ST_IDLE);
	assign is_last = (n_q == last_order_q);

	// x scaling numerator: |2*pos - d| << FRAC_BITS, plus d/2 for rounding
	always_comb begin
		pos_c   = (pos_q > d_q) ? d_q : pos_q;
		two_pos = {pos_c, 1'b0};
		xneg    = two_pos < {1'b0, d_q};
		xmag    = xneg ? ({1'b0, d_q} - two_pos) : (two_pos - {1'b0, d_q});
		xnum    = DIV_NUM_W'({xmag[D_W-1:0], {FRAC_BITS{1'b0}}}) + DIV_NUM_W'(d_q >> 1);
	end

	// q = round(x * P(n) / 2^FRAC_BITS)
	always_comb begin
		pmag = prod_q[2*VALUE_W-1] ? (2*VALUE_W)'(-prod_q) : (2*VALUE_W)'(prod_q);
		psum = pmag + ((2*VALUE_W)'(1) << (FRAC_BITS - 1));
		qmag = {1'b0, psum[FRAC_BITS +: VALUE_W-1]};
		q_c  = prod_q[2*VALUE_W-1] ? -$signed(qmag) : $signed(qmag);
	end

	// (2m+1)*q - m*P(m-1), with m = n_q
	always_comb begin
		coef_a = {n_q, 1'b1};
		num_c  = $signed({1'b0, coef_a}) * q_q - $signed({2'b00, n_q}) * cur_q;
		nmag_c = num_c[NUM_W-1] ? NUM_W'(-num_c) : NUM_W'(num_c);
		den    = n_q + ORDER_W'(1);
	end

	// quotient sign and saturation to [-1, 1]
	always_comb begin
		sat_mag = (div_quot > ONE_Q) ? ONE_Q : div_quot;
		sat_val = $signed(VALUE_W'(sat_mag));
		res_c   = neg_q ? -sat_val : sat_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q  <= LEN_RESET;
			order_count_q <= CNT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_MAX_LENGTH: begin
					max_length_q <= wr_data;
				end
				REG_ORDER_COUNT: begin
					order_count_q <= wr_data[CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_XDIV: begin
					if (div_done) begin
						n_q <= '0;
					end
				end
				ST_EMIT: begin
					if (!is_last && n_q == '0) begin
						n_q <= n_q + ORDER_W'(1);
					end
				end
				ST_ODIV: begin
					if (div_done) begin
						n_q <= n_q + ORDER_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					pos_q        <= position;
					d_q          <= d_c;
					last_order_q <= last_c;
				end
			end
			ST_LOAD: begin
				neg_q <= xneg;
			end
			ST_XDIV: begin
				if (div_done) begin
					x_q   <= res_c;
					val_q <= $signed(VALUE_W'(ONE_Q));
				end
			end
			ST_EMIT: begin
				if (!is_last && n_q == '0) begin
					val_q <= x_q;
					cur_q <= val_q;
				end
			end
			ST_MUL: begin
				prod_q <= x_q * val_q;
			end
			ST_RND: begin
				q_q <= q_c;
			end
			ST_COMB: begin
				nmag_q <= nmag_c[QUOT_W-1:0];
				neg_q  <= num_c[NUM_W-1];
			end
			ST_ODIV: begin
				if (div_done) begin
					val_q <= res_c;
					cur_q <= val_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_XDIV;
			end
			ST_XDIV: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (is_last) begin
					state_d = ST_IDLE;
				end else if (n_q == '0) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_RND;
			end
			ST_RND: begin
				state_d = ST_COMB;
			end
			ST_COMB: begin
				state_d = ST_OGO;
			end
			ST_OGO: begin
				state_d = ST_ODIV;
			end
			ST_ODIV: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy         = (state_q != ST_IDLE);
		strobe       = (state_q == ST_EMIT);
		order        = n_q;
		value        = val_q;
		last         = is_last;
		div_cmd.go   = 1'b0;
		div_cmd.mode = DIV_X;
		div_cmd.num  = xnum;
		div_cmd.dvs  = d_q;
		case (state_q)
			ST_LOAD: begin
				div_cmd.go = 1'b1;
			end
			ST_OGO: begin
				div_cmd.go   = 1'b1;
				div_cmd.mode = DIV_ORD;
				div_cmd.num  = DIV_NUM_W'(nmag_q) + DIV_NUM_W'(den >> 1);
				div_cmd.dvs  = DVS_W'(den);
			end
			default: begin
			end
		endcase
	end

	`LPE_ASSERT_NEXT(a_last_frees, strobe && last, !busy, "block still busy after last item")
	`LPE_ASSERT_NEXT(a_run_goes_on, strobe && !last, busy, "run stopped before last item")
	`LPE_ASSERT_IMPL(a_order_range, strobe, order <= last_order_q, "order beyond run length")
	`LPE_ASSERT_IMPL(a_value_range, strobe, (value <= 18'sd65536) && (value >= -18'sd65536), "value outside unit range")

endmodule

// ===== design/legpe_div.sv =====
// Shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`include "legendre_position_embedding_core_defines.svh"
module legpe_div
	import legpe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  div_cmd_t          cmd,
	output logic              done,
	output logic [QUOT_W-1:0] quot
);

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_W-1:0]    cnt_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_NUM_W-1:0] dvd_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;
	logic [DVS_W-1:0] rem_d;

	always_comb begin
		trial = {rem_q, dvd_q[DIV_NUM_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
		rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.go) begin
				busy_q <= 1'b1;
				cnt_q  <= (cmd.mode == DIV_X) ? STEP_W'(X_STEPS) : STEP_W'(ORD_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			dvs_q <= cmd.dvs;
			if (cmd.mode == DIV_X) begin
				rem_q <= DVS_W'(cmd.num >> X_STEPS);
				dvd_q <= cmd.num << (DIV_NUM_W - X_STEPS);
			end else begin
				rem_q <= DVS_W'(cmd.num >> ORD_STEPS);
				dvd_q <= cmd.num << (DIV_NUM_W - ORD_STEPS);
			end
		end else if (busy_q) begin
			rem_q <= rem_d;
			dvd_q <= {dvd_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = dvd_q[QUOT_W-1:0];

	`LPE_ASSERT_IMPL(a_rem_below_dvs, busy_q, rem_q < dvs_q, "divider remainder not below divisor")
	`LPE_ASSERT_IMPL(a_done_ends_run, done_q, !busy_q && $past(busy_q), "done without a finished run")
	`LPE_ASSERT_IMPL(a_go_when_idle, cmd.go, !busy_q, "divider started while running")

endmodule

// ===== bench/legendre_position_embedding_core_test.sv =====
// Testbench for the Legendre position embedding core: queued stimulus, predictor and checker
`timescale 1ns / 1ps
module legendre_position_embedding_core_test;
	import legpe_pkg::*;

	localparam logic [IDX_W-1:0] REG_SPARE_LO = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_SPARE_HI = IDX_W'(3);
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;
	localparam int RAND_PHASES = 10;
	localparam int PHASE_ITEMS = 29;

	typedef struct {
		logic [ORDER_W-1:0]        order;
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} term_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic [POS_BITS-1:0]       position = '0;
	logic                      wr_en = 1'b0;
	logic [IDX_W-1:0]          wr_index = '0;
	logic [LEN_W-1:0]          wr_data = '0;
	logic                      strobe;
	logic [ORDER_W-1:0]        order;
	logic signed [VALUE_W-1:0] value;
	logic                      last;

	logic [LEN_W-1:0] model_len = LEN_RESET;
	logic [CNT_W-1:0] model_cnt = CNT_RESET;

	logic [POS_BITS-1:0] pending_positions[$];
	term_t               expected_terms[$];
	term_t               head_term;

	int items_queued = 0;
	int items_taken = 0;
	int terms_seen = 0;
	int mismatches = 0;
	int settings_used = 0;
	int send_idle_pct = 9;
	int stall_cycles = 0;

	legendre_position_embedding_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.position(position),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.strobe(strobe),
		.order(order),
		.value(value),
		.last(last)
	);

	always #4 clk = ~clk;

	function automatic longint round_div(input longint num, input longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint clamp_unit(input longint v);
		longint one;
		one = longint'(1) << FRAC_BITS;
		if (v > one) return one;
		if (v < -one) return -one;
		return v;
	endfunction

	// position span: effective max_length minus one
	function automatic longint span_of(input logic [LEN_W-1:0] len);
		longint l;
		l = longint'(len);
		if (l < longint'(LEN_MIN)) l = longint'(LEN_MIN);
		if (l > longint'(LEN_MAX)) l = longint'(LEN_MAX);
		return l - 1;
	endfunction

	task automatic predict_embedding(input logic [POS_BITS-1:0] pos);
		longint d;
		longint p;
		longint one;
		longint x;
		longint prev;
		longint cur;
		longint v;
		longint m;
		longint q;
		int     cnt;
		term_t  t;
		d = span_of(model_len);
		p = longint'(pos);
		if (p > d) p = d;
		one = longint'(1) << FRAC_BITS;
		x = clamp_unit(round_div((2 * p - d) * one, d));
		cnt = int'(model_cnt);
		if (cnt < 1) cnt = 1;
		if (cnt > MAX_ORDERS) cnt = MAX_ORDERS;
		prev = 0;
		cur = one;
		for (int n = 0; n < cnt; n++) begin
			if (n == 0) begin
				v = one;
			end else if (n == 1) begin
				v = x;
			end else begin
				m = n - 1;
				q = round_div(x * cur, one);
				v = clamp_unit(round_div((2 * m + 1) * q - m * prev, m + 1));
			end
			if (n >= 1) begin
				prev = cur;
				cur = v;
			end
			t.order = ORDER_W'(n);
			t.value = VALUE_W'(v);
			t.last = (n == cnt - 1);
			expected_terms.push_back(t);
		end
	endtask

	task automatic add_position(input logic [POS_BITS-1:0] pos);
		pending_positions.push_back(pos);
		items_queued++;
	endtask

	task automatic wait_drained();
		while (items_taken != items_queued || busy || expected_terms.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_MAX_LENGTH: begin
				model_len = data;
			end
			REG_ORDER_COUNT: begin
				model_cnt = data[CNT_W-1:0];
			end
			default: ;
		endcase
	endtask

	task automatic configure(input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] cnt);
		wait_drained();
		write_reg(REG_MAX_LENGTH, len);
		write_reg(REG_ORDER_COUNT, cnt);
		settings_used++;
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				predict_embedding(position);
				items_taken++;
			end
			if (!start || !busy) begin
				if (pending_positions.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					start <= 1'b1;
					position <= pending_positions.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			terms_seen++;
			if (expected_terms.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected: order %0d value %0d last %0b",
					$time, order, value, last);
			end else begin
				head_term = expected_terms.pop_front();
				if (order !== head_term.order || value !== head_term.value
						|| last !== head_term.last) begin
					mismatches++;
					$display("%0t: expected order %0d value %0d last %0b, got order %0d value %0d last %0b",
						$time, head_term.order, head_term.value, head_term.last,
						order, value, last);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe || wr_en) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		longint           d;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] cnt;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings
		add_position(16'd0);
		add_position(16'd2047);
		add_position(16'd1023);
		add_position(16'd1024);
		add_position(16'hFFFF);
		configure(LEN_W'(2), LEN_W'(1));
		add_position(16'd0);
		add_position(16'd1);
		add_position(16'hFFFF);
		configure(LEN_W'(65536), LEN_W'(64));
		add_position(16'd0);
		add_position(16'hFFFF);
		add_position(16'h8000);
		add_position(16'h7FFF);
		// unmapped indexes leave both registers alone
		wait_drained();
		write_reg(REG_SPARE_LO, '1);
		write_reg(REG_SPARE_HI, LEN_W'(3));
		add_position(16'd7);
		// out of range settings, then an in-range one
		configure(LEN_W'(0), LEN_W'(0));
		add_position(16'd0);
		add_position(16'd7);
		configure('1, LEN_W'(127));
		add_position(16'd40000);
		add_position(16'd12345);
		configure(LEN_W'(3), LEN_W'(65));
		add_position(16'd0);
		add_position(16'd1);
		add_position(16'd2);
		configure(LEN_W'(1000), LEN_W'(2));
		add_position(16'd500);
		add_position(16'd999);
		add_position(16'd1000);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(5))
				0: len = LEN_W'(2);
				1: len = LEN_W'(65536);
				2: len = LEN_W'($urandom_range(2, 65536));
				3: len = LEN_W'($urandom_range(2, 300));
				4: len = LEN_W'($urandom_range(0, 131071));
				default: len = LEN_RESET;
			endcase
			if (ph == 2 || ph == 5) begin
				cnt = LEN_W'(64);
			end else if (ph == 8) begin
				cnt = ($urandom_range(1) != 0) ? LEN_W'($urandom_range(65, 127)) : LEN_W'(0);
			end else begin
				cnt = LEN_W'($urandom_range(1, 10));
			end
			configure(len, cnt);
			send_idle_pct = (ph < 4) ? 9 : (ph < 7) ? 61 : 0;
			d = span_of(model_len);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				case ($urandom_range(9))
					0: add_position('0);
					1: add_position(POS_BITS'(d));
					2: add_position((d < 65535) ? POS_BITS'(d + 1) : '1);
					3, 4: add_position(POS_BITS'($urandom_range(0, 65535)));
					default: add_position(POS_BITS'($urandom_range(0, int'(d))));
				endcase
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d positions over %0d register settings, %0d results checked.",
			items_taken, settings_used, terms_seen);
		$display("Sender gaps at 9 and 61 percent and none; extremes of length and order count.");
		if (mismatches == 0 && expected_terms.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d results never seen", mismatches, expected_terms.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== legendre_position_embedding_core.f =====
+incdir+design
design/legpe_pkg.sv
design/legpe_div.sv
design/legendre_position_embedding_core.sv
bench/legendre_position_embedding_core_test.sv
